FILE: sv/kplsm_pkg.sv
`default_nettype none
package kplsm_pkg;

    localparam int WINDOW_DEPTH_DEF = 16;

    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int STATUS_W  = 2;

    // window length including the newest level, before saturation at the depth
    localparam int WIN_LEN_RESET = 6;

    localparam logic [DATA_W-1:0] MIN_LEVEL_RESET       = 32'd1000000;
    localparam logic [DATA_W-1:0] MAX_LEVEL_RESET       = 32'd1000000000;
    localparam logic [DATA_W-1:0] READY_THRESHOLD_RESET = 32'd2000000;
    localparam logic [DATA_W-1:0] INITIAL_LEVEL_RESET   = 32'd5000000;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_READY_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_LEVEL   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_READY    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CHARGING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_WARNING  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    localparam logic MODE_ADD     = 1'b0;
    localparam logic MODE_CONSUME = 1'b1;

endpackage
`default_nettype wire

FILE: sv/kplsm_cell.sv
`default_nettype none
module kplsm_cell #(
    parameter int WINDOW_DEPTH = kplsm_pkg::WINDOW_DEPTH_DEF,
    parameter int POS          = 0
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 shift_en,
    input  wire logic [$clog2(WINDOW_DEPTH+1)-1:0]    win_len,
    input  wire logic [kplsm_pkg::DATA_W-1:0]         level,
    input  wire logic [kplsm_pkg::DATA_W-1:0]         prev_val,
    input  wire logic                                 prev_kept,
    output logic      [kplsm_pkg::DATA_W-1:0]         val,
    output logic                                      kept,
    output logic                                      beats
);

    localparam int LEN_W = $clog2(WINDOW_DEPTH+1);
    localparam logic [LEN_W-1:0] NEXT_POS = LEN_W'(POS + 1);

    logic [kplsm_pkg::DATA_W-1:0] val_reg;
    logic                         vld_reg;

    // an entry survives the cut only if it lies within the newest win_len - 1
    assign kept  = vld_reg && (NEXT_POS < win_len);
    assign beats = !kept || (level > val_reg);
    assign val   = val_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (shift_en) begin
            vld_reg <= prev_kept;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            val_reg <= prev_val;
        end
    end

endmodule
`default_nettype wire

FILE: sv/key_pool_level_status_monitor.sv
// Key pool level and status monitor.
// An input transfer first settles the level and the window length, setting busy_reg;
// the window compare across the cell chain then loads the result and raises m_valid.
// No new input item is taken while one is in flight, nor while a stalled result
// is still waiting for m_ready.
// Reset (synchronous, active low) loads the register defaults, the initial
// level into the pool, clears the window and sets the status to empty.
`default_nettype none
module key_pool_level_status_monitor #(
    parameter int WINDOW_DEPTH = kplsm_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_mode,
    input  wire logic [kplsm_pkg::DATA_W-1:0]        s_amount,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_accepted,
    output logic      [kplsm_pkg::DATA_W-1:0]        m_level,
    output logic      [kplsm_pkg::STATUS_W-1:0]      m_pool_status,
    output logic                                     m_rising,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [kplsm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [kplsm_pkg::DATA_W-1:0]        cfg_data
);

    localparam int LEN_W = $clog2(WINDOW_DEPTH+1);
    localparam int DW    = kplsm_pkg::DATA_W;
    localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(WINDOW_DEPTH);
    localparam logic [LEN_W-1:0] LEN_RESET =
        (kplsm_pkg::WIN_LEN_RESET > WINDOW_DEPTH) ? LEN_W'(WINDOW_DEPTH)
                                                  : LEN_W'(kplsm_pkg::WIN_LEN_RESET);

    logic [DW-1:0] min_level_reg;
    logic [DW-1:0] max_level_reg;
    logic [DW-1:0] ready_thr_reg;

    logic [DW-1:0]                   pool_level_reg;
    logic [LEN_W-1:0]                win_len_reg;
    logic [LEN_W-1:0]                usa_reg;
    logic [kplsm_pkg::STATUS_W-1:0]  status_reg;
    logic [kplsm_pkg::STATUS_W-1:0]  status_next;
    logic                            rising_reg;

    logic busy_reg;
    logic acc_reg;
    logic upd_reg;

    logic                            m_valid_reg;
    logic                            out_acc_reg;
    logic [DW-1:0]                   out_level_reg;
    logic [kplsm_pkg::STATUS_W-1:0]  out_status_reg;
    logic                            out_rising_reg;

    logic          in_xfer;
    logic          cfg_xfer;
    logic [DW:0]   sum;
    logic          add_ok;
    logic          sub_ok;
    logic          shift_en;
    logic          up;

    logic [DW-1:0]                cell_val  [WINDOW_DEPTH];
    wire logic [WINDOW_DEPTH-1:0] cell_kept;
    wire logic [WINDOW_DEPTH-1:0] cell_beats;

    assign s_ready   = !busy_reg && (!m_valid_reg || m_ready);
    assign in_xfer   = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    assign sum    = {1'b0, pool_level_reg} + {1'b0, s_amount};
    assign add_ok = sum < {1'b0, max_level_reg};
    assign sub_ok = pool_level_reg > s_amount;

    assign shift_en = busy_reg && upd_reg;
    assign up       = &cell_beats;

    generate
        for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
            if (i == 0) begin : g_head
                kplsm_cell #(.WINDOW_DEPTH(WINDOW_DEPTH), .POS(i)) u_cell (
                    .aclk      (aclk),
                    .aresetn   (aresetn),
                    .shift_en  (shift_en),
                    .win_len   (win_len_reg),
                    .level     (pool_level_reg),
                    .prev_val  (pool_level_reg),
                    .prev_kept (1'b1),
                    .val       (cell_val[i]),
                    .kept      (cell_kept[i]),
                    .beats     (cell_beats[i])
                );
            end else begin : g_body
                kplsm_cell #(.WINDOW_DEPTH(WINDOW_DEPTH), .POS(i)) u_cell (
                    .aclk      (aclk),
                    .aresetn   (aresetn),
                    .shift_en  (shift_en),
                    .win_len   (win_len_reg),
                    .level     (pool_level_reg),
                    .prev_val  (cell_val[i-1]),
                    .prev_kept (cell_kept[i-1]),
                    .val       (cell_val[i]),
                    .kept      (cell_kept[i]),
                    .beats     (cell_beats[i])
                );
            end
        end
    endgenerate

    always_comb begin
        if (pool_level_reg >= ready_thr_reg) begin
            status_next = kplsm_pkg::ST_READY;
        end else if (pool_level_reg > min_level_reg &&
                     ((up && status_reg != kplsm_pkg::ST_READY) ||
                      status_reg == kplsm_pkg::ST_EMPTY)) begin
            status_next = kplsm_pkg::ST_CHARGING;
        end else if (pool_level_reg > min_level_reg &&
                     status_reg != kplsm_pkg::ST_CHARGING) begin
            status_next = kplsm_pkg::ST_WARNING;
        end else if (pool_level_reg <= min_level_reg) begin
            status_next = kplsm_pkg::ST_EMPTY;
        end else begin
            status_next = status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_level_reg  <= kplsm_pkg::MIN_LEVEL_RESET;
            max_level_reg  <= kplsm_pkg::MAX_LEVEL_RESET;
            ready_thr_reg  <= kplsm_pkg::READY_THRESHOLD_RESET;
            pool_level_reg <= kplsm_pkg::INITIAL_LEVEL_RESET;
            win_len_reg    <= LEN_RESET;
            usa_reg        <= '0;
            status_reg     <= kplsm_pkg::ST_EMPTY;
            rising_reg     <= 1'b0;
            busy_reg       <= 1'b0;
            acc_reg        <= 1'b0;
            upd_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // first step: settle the level and the window length
            if (in_xfer) begin
                busy_reg <= 1'b1;
                if (s_mode == kplsm_pkg::MODE_ADD) begin
                    acc_reg <= add_ok;
                    upd_reg <= 1'b1;
                    if (add_ok) begin
                        pool_level_reg <= sum[DW-1:0];
                    end
                    win_len_reg <= (usa_reg >= DEPTH_L) ? DEPTH_L : usa_reg + 1'b1;
                    usa_reg     <= '0;
                end else begin
                    acc_reg <= sub_ok;
                    upd_reg <= sub_ok;
                    if (sub_ok) begin
                        pool_level_reg <= pool_level_reg - s_amount;
                    end
                end
            end

            // second step: cells shift and compare, status settles, result loads
            if (busy_reg) begin
                busy_reg    <= 1'b0;
                m_valid_reg <= 1'b1;
                if (upd_reg) begin
                    status_reg <= status_next;
                    rising_reg <= up;
                    if (usa_reg != DEPTH_L) begin
                        usa_reg <= usa_reg + 1'b1;
                    end
                end
            end

            if (cfg_xfer) begin
                unique case (cfg_index)
                    kplsm_pkg::REG_MIN_LEVEL:       min_level_reg  <= cfg_data;
                    kplsm_pkg::REG_MAX_LEVEL:       max_level_reg  <= cfg_data;
                    kplsm_pkg::REG_READY_THRESHOLD: ready_thr_reg  <= cfg_data;
                    kplsm_pkg::REG_INITIAL_LEVEL:   pool_level_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            out_acc_reg    <= acc_reg;
            out_level_reg  <= pool_level_reg;
            out_status_reg <= upd_reg ? status_next : status_reg;
            out_rising_reg <= upd_reg ? up : rising_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_accepted    = out_acc_reg;
    assign m_level       = out_level_reg;
    assign m_pool_status = out_status_reg;
    assign m_rising      = out_rising_reg;

endmodule
`default_nettype wire

FILE: sv/kplsm_checker.sv
`default_nettype none
module kplsm_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_valid,
    input wire logic                                s_ready,
    input wire logic                                s_mode,
    input wire logic [kplsm_pkg::DATA_W-1:0]        s_amount,
    input wire logic                                m_valid,
    input wire logic                                m_ready,
    input wire logic                                m_accepted,
    input wire logic [kplsm_pkg::DATA_W-1:0]        m_level,
    input wire logic [kplsm_pkg::STATUS_W-1:0]      m_pool_status,
    input wire logic                                m_rising
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_level) && $stable(m_pool_status)
            && $stable(m_accepted) && $stable(m_rising))
        else $error("result changed while stalled");

    // hold a waiting input item
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_mode) && $stable(s_amount))
        else $error("input changed while waiting");

    // one item in flight: no transfer in the cycle after a transfer
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    // the result shows once its transfer has passed the update and compare steps
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> ##2 m_valid)
        else $error("result missing two cycles after transfer");

    a_reset_idle: assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

endmodule

bind key_pool_level_status_monitor kplsm_checker u_kplsm_checker (.*);
`default_nettype wire

FILE: tb/sv/testbench.sv
`default_nettype none
module testbench;

    localparam int DEPTH       = kplsm_pkg::WINDOW_DEPTH_DEF;
    localparam int DW          = kplsm_pkg::DATA_W;
    localparam int SW          = kplsm_pkg::STATUS_W;
    localparam int IW          = kplsm_pkg::CFG_IDX_W;
    localparam int LATENCY     = 2;
    localparam int ITEMS_PHASE = 110;
    localparam int PHASES      = 10;

    typedef struct packed {
        logic          accepted;
        logic [DW-1:0] level;
        logic [SW-1:0] status;
        logic          rising;
    } pool_result_t;

    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          s_valid   = 1'b0;
    logic          s_mode    = kplsm_pkg::MODE_ADD;
    logic [DW-1:0] s_amount  = '0;
    logic          m_ready   = 1'b0;
    logic          cfg_valid = 1'b0;
    logic [IW-1:0] cfg_index = kplsm_pkg::REG_MIN_LEVEL;
    logic [DW-1:0] cfg_data  = '0;
    wire           s_ready;
    wire           m_valid;
    wire           m_accepted;
    wire [DW-1:0]  m_level;
    wire [SW-1:0]  m_pool_status;
    wire           m_rising;
    wire           cfg_ready;

    key_pool_level_status_monitor uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_amount      (s_amount),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_accepted    (m_accepted),
        .m_level       (m_level),
        .m_pool_status (m_pool_status),
        .m_rising      (m_rising),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predictor state
    logic [DW-1:0] min_lvl, max_lvl, ready_lvl, init_lvl;
    logic [DW-1:0] pool_lvl;
    logic [DW-1:0] level_hist [DEPTH];
    int unsigned   hist_fill, hist_len, since_add;
    logic [SW-1:0] pool_stat;
    logic          pool_rise;

    pool_result_t expected_pool_results [$];
    int unsigned  mismatch_count = 0;
    bit           no_idle = 1'b0;
    int unsigned  ready_hold = 0;

    function automatic void reset_pool_model();
        min_lvl   = kplsm_pkg::MIN_LEVEL_RESET;
        max_lvl   = kplsm_pkg::MAX_LEVEL_RESET;
        ready_lvl = kplsm_pkg::READY_THRESHOLD_RESET;
        init_lvl  = kplsm_pkg::INITIAL_LEVEL_RESET;
        pool_lvl  = init_lvl;
        foreach (level_hist[i]) level_hist[i] = '0;
        hist_fill = 0;
        hist_len  = (kplsm_pkg::WIN_LEN_RESET > DEPTH) ? DEPTH : kplsm_pkg::WIN_LEN_RESET;
        since_add = 0;
        pool_stat = kplsm_pkg::ST_EMPTY;
        pool_rise = 1'b0;
    endfunction

    function automatic void push_level_window();
        int unsigned keep;
        bit up;
        keep = (hist_len > 0) ? hist_len - 1 : 0;
        if (keep > DEPTH - 1) keep = DEPTH - 1;
        if (hist_fill > keep) hist_fill = keep;
        up = 1'b1;
        for (int i = 0; i < hist_fill; i++) begin
            if (!(pool_lvl > level_hist[i])) up = 1'b0;
        end
        for (int i = hist_fill; i > 0; i--) level_hist[i] = level_hist[i-1];
        level_hist[0] = pool_lvl;
        hist_fill++;
        pool_rise = up;
        if (since_add < DEPTH) since_add++;

        if (pool_lvl >= ready_lvl) begin
            pool_stat = kplsm_pkg::ST_READY;
        end else if (pool_lvl > min_lvl &&
                     ((up && pool_stat != kplsm_pkg::ST_READY) ||
                      pool_stat == kplsm_pkg::ST_EMPTY)) begin
            pool_stat = kplsm_pkg::ST_CHARGING;
        end else if (pool_lvl > min_lvl && pool_stat != kplsm_pkg::ST_CHARGING) begin
            pool_stat = kplsm_pkg::ST_WARNING;
        end else if (pool_lvl <= min_lvl) begin
            pool_stat = kplsm_pkg::ST_EMPTY;
        end
    endfunction

    function automatic pool_result_t predict_pool_item(logic mode, logic [DW-1:0] amount);
        pool_result_t r;
        logic [DW:0] sum;
        r.accepted = 1'b0;
        if (mode == kplsm_pkg::MODE_ADD) begin
            sum = {1'b0, pool_lvl} + {1'b0, amount};
            if (sum < {1'b0, max_lvl}) begin
                pool_lvl   = sum[DW-1:0];
                r.accepted = 1'b1;
            end
            hist_len  = (since_add + 1 > DEPTH) ? DEPTH : since_add + 1;
            since_add = 0;
            push_level_window();
        end else if (pool_lvl > amount) begin
            pool_lvl   = pool_lvl - amount;
            r.accepted = 1'b1;
            push_level_window();
        end
        r.level  = pool_lvl;
        r.status = pool_stat;
        r.rising = pool_rise;
        return r;
    endfunction

    function automatic void apply_pool_reg(logic [IW-1:0] idx, logic [DW-1:0] v);
        case (idx)
            kplsm_pkg::REG_MIN_LEVEL:       min_lvl   = v;
            kplsm_pkg::REG_MAX_LEVEL:       max_lvl   = v;
            kplsm_pkg::REG_READY_THRESHOLD: ready_lvl = v;
            kplsm_pkg::REG_INITIAL_LEVEL: begin
                init_lvl = v;
                pool_lvl = v;
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string field, logic [DW-1:0] got,
                                   logic [DW-1:0] want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("mismatch %s: got %0h want %0h", field, got, want);
    endtask

    task automatic check_pool_result();
        pool_result_t want;
        if (expected_pool_results.size() == 0) begin
            report_mismatch("unexpected result", m_level, '0);
        end else begin
            want = expected_pool_results.pop_front();
            if (m_accepted !== want.accepted)
                report_mismatch("accepted", DW'(m_accepted), DW'(want.accepted));
            if (m_level !== want.level)
                report_mismatch("level", m_level, want.level);
            if (m_pool_status !== want.status)
                report_mismatch("status", DW'(m_pool_status), DW'(want.status));
            if (m_rising !== want.rising)
                report_mismatch("rising", DW'(m_rising), DW'(want.rising));
        end
    endtask

    // result side: stall for a random gap after each transfer, none while no_idle is set
    always @(posedge aclk) begin : result_sink
        int unsigned gap;
        if (aresetn && m_valid === 1'b1 && m_ready) check_pool_result();
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_hold <= 0;
        end else if (m_valid === 1'b1 && m_ready) begin
            gap = no_idle ? 0 : $urandom_range(0, 7);
            ready_hold <= gap;
            m_ready    <= (gap == 0);
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready    <= (ready_hold == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_pool_item(logic mode, logic [DW-1:0] amount);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_mode   <= mode;
        s_amount <= amount;
        do @(posedge aclk); while (!s_ready);
        expected_pool_results.push_back(predict_pool_item(mode, amount));
    endtask

    // hold off until every result is back, then let the pipeline settle
    task automatic wait_pool_drained();
        s_valid <= 1'b0;
        while (expected_pool_results.size() != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    task automatic write_pool_reg(logic [IW-1:0] idx, logic [DW-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        apply_pool_reg(idx, v);
    endtask

    task automatic close_reg_writes();
        cfg_valid <= 1'b0;
    endtask

    // walk the status through ready, warning, empty, charging and the hold case
    task automatic test_default_thresholds();
        send_pool_item(kplsm_pkg::MODE_CONSUME, 32'd0);
        send_pool_item(kplsm_pkg::MODE_CONSUME, 32'd3500000);
        send_pool_item(kplsm_pkg::MODE_CONSUME, 32'd600000);
        send_pool_item(kplsm_pkg::MODE_ADD,     32'd300000);
        send_pool_item(kplsm_pkg::MODE_ADD,     32'd100000);
        send_pool_item(kplsm_pkg::MODE_CONSUME, 32'd0);
        send_pool_item(kplsm_pkg::MODE_ADD,     32'd800000);
        send_pool_item(kplsm_pkg::MODE_CONSUME, 32'd5000000);
        send_pool_item(kplsm_pkg::MODE_CONSUME, 32'd2100000);
        send_pool_item(kplsm_pkg::MODE_ADD,     32'hFFFFFFFF);
        send_pool_item(kplsm_pkg::MODE_CONSUME, 32'hFFFFFFFF);
        send_pool_item(kplsm_pkg::MODE_ADD,     32'd0);
        wait_pool_drained();
    endtask

    task automatic test_register_extremes();
        write_pool_reg(kplsm_pkg::REG_MAX_LEVEL, 32'd0);
        write_pool_reg(kplsm_pkg::REG_MIN_LEVEL, 32'hFFFFFFFF);
        write_pool_reg(kplsm_pkg::REG_READY_THRESHOLD, 32'hFFFFFFFF);
        write_pool_reg(kplsm_pkg::REG_INITIAL_LEVEL, 32'hFFFFFFFF);
        close_reg_writes();
        send_pool_item(kplsm_pkg::MODE_ADD,     32'd0);
        send_pool_item(kplsm_pkg::MODE_CONSUME, 32'd0);
        send_pool_item(kplsm_pkg::MODE_CONSUME, 32'h7FFFFFFF);
        wait_pool_drained();

        write_pool_reg(kplsm_pkg::REG_INITIAL_LEVEL, 32'd0);
        write_pool_reg(kplsm_pkg::REG_MIN_LEVEL, 32'd0);
        write_pool_reg(kplsm_pkg::REG_READY_THRESHOLD, 32'd0);
        write_pool_reg(kplsm_pkg::REG_MAX_LEVEL, 32'hFFFFFFFF);
        close_reg_writes();
        send_pool_item(kplsm_pkg::MODE_CONSUME, 32'd0);
        send_pool_item(kplsm_pkg::MODE_ADD,     32'hFFFFFFFE);
        send_pool_item(kplsm_pkg::MODE_ADD,     32'd1);
        send_pool_item(kplsm_pkg::MODE_CONSUME, 32'hFFFFFFFE);
        send_pool_item(kplsm_pkg::MODE_CONSUME, 32'hFFFFFFFD);
        wait_pool_drained();
    endtask

    function automatic logic [DW-1:0] pick_reg_value(logic [DW-1:0] v);
        case ($urandom_range(0, 11))
            0: return '0;
            1: return '1;
            2: return $urandom;
            default: return v;
        endcase
    endfunction

    task automatic test_random_traffic();
        int unsigned   scale, add_pct, lo, rt, hi;
        logic          mode;
        logic [DW-1:0] amount;
        for (int p = 0; p < PHASES; p++) begin
            scale = 1 << $urandom_range(3, 29);
            lo    = $urandom_range(0, scale);
            rt    = lo + $urandom_range(0, scale);
            hi    = rt + $urandom_range(0, 2 * scale);
            write_pool_reg(kplsm_pkg::REG_MIN_LEVEL, pick_reg_value(lo));
            write_pool_reg(kplsm_pkg::REG_MAX_LEVEL, pick_reg_value(hi));
            write_pool_reg(kplsm_pkg::REG_READY_THRESHOLD, pick_reg_value(rt));
            write_pool_reg(kplsm_pkg::REG_INITIAL_LEVEL,
                           pick_reg_value($urandom_range(0, hi)));
            close_reg_writes();
            no_idle = ($urandom_range(0, 3) == 0);
            // rare adds let the window run up to its full depth
            case ($urandom_range(0, 2))
                0:       add_pct = 8;
                1:       add_pct = 50;
                default: add_pct = 75;
            endcase
            for (int n = 0; n < ITEMS_PHASE; n++) begin
                mode = ($urandom_range(0, 99) < add_pct) ? kplsm_pkg::MODE_ADD
                                                         : kplsm_pkg::MODE_CONSUME;
                case ($urandom_range(0, 15))
                    0:       amount = '0;
                    1:       amount = '1;
                    2:       amount = $urandom;
                    default: amount = $urandom_range(0, scale / 2);
                endcase
                send_pool_item(mode, amount);
            end
            wait_pool_drained();
            no_idle = 1'b0;
        end
    endtask

    initial begin
        reset_pool_model();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_thresholds();
        test_register_extremes();
        test_random_traffic();
        wait_pool_drained();
        if (mismatch_count == 0 && expected_pool_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire
